FILE: rtl/core/mfb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfb_pkg: shared types and constants of the frame buffer drawing engine
// Opcodes, defaults and the command/status structs between the controller
// and the datapath.
// ----------------------------------------------------------------------------
package mfb_pkg;

    localparam int DEF_SCREEN_WIDTH  = 128;
    localparam int DEF_SCREEN_HEIGHT = 64;

    localparam logic [2:0] OP_CLEAR  = 3'd0;
    localparam logic [2:0] OP_SET    = 3'd1;
    localparam logic [2:0] OP_POINT  = 3'd2;
    localparam logic [2:0] OP_LINE   = 3'd3;
    localparam logic [2:0] OP_CIRCLE = 3'd4;
    localparam logic [2:0] OP_READ   = 3'd5;

    localparam logic [7:0] BYTE_ONES  = 8'hff;
    localparam logic [7:0] BYTE_ZEROS = 8'h00;

    // controller -> datapath
    typedef struct packed {
        logic load;       // capture the command fields
        logic fill_step;  // write one byte of a fill, advance sweep address
        logic fill_ones;  // fill byte is all ones (else all zeros)
        logic line_init;  // set up line stepper
        logic line_step;  // advance line stepper one point
        logic circ_init;  // set up circle stepper
        logic circ_next;  // advance circle stepper (after 8 octant points)
        logic oct_next;   // move to next octant point
        logic rd_issue;   // issue memory read of the current plot address
        logic wr_issue;   // write back modified byte
        logic rb_issue;   // issue read-back byte read
        logic rb_take;    // latch read-back data into result
        logic clr_result; // clear the result for a non-read command
    } mfb_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic fill_last;
        logic line_last;
        logic circ_done;
        logic oct_last;
        logic on_screen;
    } mfb_sts_t;

endpackage

FILE: rtl/core/mfb_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfb_datapath: frame memory, line and circle steppers, pixel RMW
// Holds the PAGES*SCREEN_WIDTH-byte store (1024 bytes at 128x64); all stepping is driven by controller commands.
// ----------------------------------------------------------------------------
module mfb_datapath
    import mfb_pkg::*;
#(
    parameter int SCREEN_WIDTH  = DEF_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = DEF_SCREEN_HEIGHT
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  mfb_cmd_t   cmd,
    output mfb_sts_t   sts,
    input  logic [2:0] opcode,
    input  logic [7:0] x_a,
    input  logic [7:0] y_a,
    input  logic [7:0] x_b,
    input  logic [7:0] y_b,
    input  logic [7:0] radius,
    input  logic       ink,
    input  logic [2:0] read_page,
    input  logic [6:0] read_column,
    output logic [7:0] read_data,
    output logic       was_read
);

    localparam int PAGES = (SCREEN_HEIGHT + 7) / 8;
    localparam int DEPTH = PAGES * SCREEN_WIDTH;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [7:0] mem [DEPTH];
    logic [7:0] mem_q;

    // captured command
    logic [2:0] op_reg;
    logic [7:0] xa_reg, ya_reg, xb_reg, yb_reg, r_reg;
    logic       ink_reg;
    logic [2:0] pg_reg;
    logic [6:0] col_reg;

    // fill sweep
    logic [AW-1:0] fill_addr_reg;

    // line stepper (coordinates kept mod 256)
    logic [7:0] lx_reg, ly_reg, dx_reg, dy_reg, dist_reg;
    logic [8:0] ex_reg, ey_reg;
    logic       sxn_reg, syn_reg, sxz_reg, syz_reg;
    logic [8:0] lcnt_reg;

    // circle stepper
    logic signed [9:0]  ca_reg, cb_reg;
    logic signed [11:0] d_reg;
    logic [2:0]         oct_reg;

    // plot point and address
    logic [7:0]    px, py;
    logic [AW-1:0] paddr_reg;
    logic [2:0]    pbit_reg;
    logic          pink_reg;

    always_comb
    begin
        logic [7:0] a8, b8;
        a8 = ca_reg[7:0];
        b8 = cb_reg[7:0];
        px = lx_reg;
        py = ly_reg;
        if (op_reg == OP_POINT)
        begin
            px = xa_reg;
            py = ya_reg;
        end
        else if (op_reg == OP_CIRCLE)
        begin
            case (oct_reg)
                3'd0:    begin px = xa_reg + a8; py = ya_reg - b8; end
                3'd1:    begin px = xa_reg + b8; py = ya_reg - a8; end
                3'd2:    begin px = xa_reg + b8; py = ya_reg + a8; end
                3'd3:    begin px = xa_reg + a8; py = ya_reg + b8; end
                3'd4:    begin px = xa_reg - a8; py = ya_reg + b8; end
                3'd5:    begin px = xa_reg - b8; py = ya_reg + a8; end
                3'd6:    begin px = xa_reg - a8; py = ya_reg - b8; end
                default: begin px = xa_reg - b8; py = ya_reg - a8; end
            endcase
        end
    end

    logic on_scr;
    assign on_scr = ({1'b0, px} < 9'(SCREEN_WIDTH)) && ({1'b0, py} < 9'(SCREEN_HEIGHT));

    logic [AW-1:0] plot_addr;
    assign plot_addr = AW'(32'(py[7:3]) * SCREEN_WIDTH + 32'(px));

    logic rb_ok;
    assign rb_ok = (32'(pg_reg) < PAGES) && (32'(col_reg) < SCREEN_WIDTH);

    // memory: one write port, one registered read
    always_ff @(posedge clk)
    begin
        if (cmd.fill_step)
            mem[fill_addr_reg] <= cmd.fill_ones ? BYTE_ONES : BYTE_ZEROS;
        else if (cmd.wr_issue)
            mem[paddr_reg] <= pink_reg ? (mem_q | (8'd1 << pbit_reg))
                                       : (mem_q & ~(8'd1 << pbit_reg));
        if (cmd.rd_issue)
            mem_q <= mem[plot_addr];
        else if (cmd.rb_issue)
            mem_q <= mem[AW'(32'(pg_reg) * SCREEN_WIDTH + 32'(col_reg))];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg  <= opcode;
            xa_reg  <= x_a;
            ya_reg  <= y_a;
            xb_reg  <= x_b;
            yb_reg  <= y_b;
            r_reg   <= radius;
            ink_reg <= ink;
            pg_reg  <= read_page;
            col_reg <= read_column;
        end
        if (cmd.rd_issue)
        begin
            paddr_reg <= plot_addr;
            pbit_reg  <= py[2:0];
            pink_reg  <= (op_reg == OP_CIRCLE) ? 1'b1 : ink_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_addr_reg <= '0;
            read_data     <= '0;
            was_read      <= 1'b0;
        end
        else
        begin
            if (cmd.load)
                fill_addr_reg <= '0;
            else if (cmd.fill_step)
                fill_addr_reg <= fill_addr_reg + 1'b1;
            if (cmd.rb_take)
            begin
                read_data <= rb_ok ? mem_q : BYTE_ZEROS;
                was_read  <= 1'b1;
            end
            else if (cmd.clr_result)
            begin
                read_data <= BYTE_ZEROS;
                was_read  <= 1'b0;
            end
        end
    end

    // line stepper
    always_ff @(posedge clk)
    begin
        logic [7:0] adx, ady;
        logic [8:0] nex, ney;
        adx = (xb_reg >= xa_reg) ? xb_reg - xa_reg : xa_reg - xb_reg;
        ady = (yb_reg >= ya_reg) ? yb_reg - ya_reg : ya_reg - yb_reg;
        nex = ex_reg + {1'b0, dx_reg};
        ney = ey_reg + {1'b0, dy_reg};
        if (cmd.line_init)
        begin
            lx_reg   <= xa_reg;
            ly_reg   <= ya_reg;
            dx_reg   <= adx;
            dy_reg   <= ady;
            dist_reg <= (adx > ady) ? adx : ady;
            lcnt_reg <= {1'b0, ((adx > ady) ? adx : ady)} + 9'd1;
            sxn_reg  <= xb_reg < xa_reg;
            syn_reg  <= yb_reg < ya_reg;
            sxz_reg  <= xb_reg == xa_reg;
            syz_reg  <= yb_reg == ya_reg;
            ex_reg   <= '0;
            ey_reg   <= '0;
        end
        else if (cmd.line_step)
        begin
            lcnt_reg <= lcnt_reg - 9'd1;
            if (nex > {1'b0, dist_reg})
            begin
                ex_reg <= nex - {1'b0, dist_reg};
                if (!sxz_reg)
                    lx_reg <= sxn_reg ? lx_reg - 8'd1 : lx_reg + 8'd1;
            end
            else
                ex_reg <= nex;
            if (ney > {1'b0, dist_reg})
            begin
                ey_reg <= ney - {1'b0, dist_reg};
                if (!syz_reg)
                    ly_reg <= syn_reg ? ly_reg - 8'd1 : ly_reg + 8'd1;
            end
            else
                ey_reg <= ney;
        end
    end

    // circle stepper
    always_ff @(posedge clk)
    begin
        logic signed [9:0] an;
        an = ca_reg + 10'sd1;
        if (cmd.circ_init)
        begin
            ca_reg  <= '0;
            cb_reg  <= $signed({2'b00, r_reg});
            d_reg   <= 12'sd3 - $signed({3'b000, r_reg, 1'b0});
            oct_reg <= '0;
        end
        else if (cmd.circ_next)
        begin
            oct_reg <= '0;
            ca_reg  <= an;
            if (d_reg < 0)
                d_reg <= d_reg + 12'(4 * an) + 12'sd6;
            else
            begin
                d_reg  <= d_reg + 12'sd10 + 12'(4 * (an - cb_reg));
                cb_reg <= cb_reg - 10'sd1;
            end
        end
        else if (cmd.oct_next)
            oct_reg <= oct_reg + 3'd1;
    end

    assign sts.fill_last = (32'(fill_addr_reg) == DEPTH - 1);
    assign sts.line_last = (lcnt_reg == 9'd0);
    assign sts.circ_done = (ca_reg > cb_reg);
    assign sts.oct_last  = (oct_reg == 3'd7);
    assign sts.on_screen = on_scr;

endmodule

FILE: rtl/core/mfb_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfb_ctrl: command sequencer
// Clears the store after reset, then accepts a command, steps the datapath
// through fills, pixel RMWs and byte read-backs, and offers one result.
// ----------------------------------------------------------------------------
module mfb_ctrl
    import mfb_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic [2:0] opcode,
    output logic       in_stall,
    output logic       out_valid,
    input  logic       out_stall,
    output mfb_cmd_t   cmd,
    input  mfb_sts_t   sts
);

    typedef enum logic [2:0] {
        S_BOOT, S_IDLE, S_DISPATCH, S_FILL, S_PLOT, S_WRITE, S_READ, S_DONE
    } state_t;

    state_t   state_reg;
    logic     is_read_reg;
    logic [2:0] op_reg;

    logic accept, deliver;
    assign deliver  = out_valid && !out_stall;
    // a new command may enter once the previous result is out or being taken
    assign in_stall = !(state_reg == S_IDLE && (!out_valid || !out_stall));
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        cmd = '0;
        cmd.load = accept;
        case (state_reg)
            S_BOOT:  cmd.fill_step = 1'b1;
            S_DISPATCH:
            begin
                case (op_reg)
                    OP_LINE:   cmd.line_init = 1'b1;
                    OP_CIRCLE: cmd.circ_init = 1'b1;
                    OP_READ:   cmd.rb_issue  = 1'b1;
                    default:   ;
                endcase
            end
            S_FILL:
            begin
                cmd.fill_step = 1'b1;
                cmd.fill_ones = (op_reg == OP_SET);
            end
            S_PLOT:  cmd.rd_issue  = sts.on_screen && !(op_reg == OP_CIRCLE && sts.circ_done);
            S_WRITE:
            begin
                cmd.wr_issue = 1'b1;
                case (op_reg)
                    OP_LINE: cmd.line_step = 1'b1;
                    OP_CIRCLE:
                    begin
                        cmd.oct_next  = !sts.oct_last;
                        cmd.circ_next = sts.oct_last;
                    end
                    default: ;
                endcase
            end
            S_READ:  cmd.rb_take = 1'b1;
            S_DONE:  cmd.clr_result = !is_read_reg;
            default: ;
        endcase
        // off-screen points skip the write but still advance
        if (state_reg == S_PLOT && !cmd.rd_issue)
        begin
            if (op_reg == OP_LINE)
                cmd.line_step = 1'b1;
            else if (op_reg == OP_CIRCLE && !sts.circ_done)
            begin
                cmd.oct_next  = !sts.oct_last;
                cmd.circ_next = sts.oct_last;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_BOOT;
            out_valid   <= 1'b0;
            is_read_reg <= 1'b0;
            op_reg      <= OP_CLEAR;
        end
        else
        begin
            if (deliver)
                out_valid <= 1'b0;
            case (state_reg)
                S_BOOT:
                    if (sts.fill_last)
                        state_reg <= S_IDLE;
                S_IDLE:
                    if (accept)
                    begin
                        op_reg      <= opcode;
                        is_read_reg <= (opcode == OP_READ);
                        state_reg   <= S_DISPATCH;
                    end
                S_DISPATCH:
                    case (op_reg)
                        OP_CLEAR, OP_SET:  state_reg <= S_FILL;
                        OP_POINT, OP_LINE,
                        OP_CIRCLE:         state_reg <= S_PLOT;
                        OP_READ:           state_reg <= S_READ;
                        default:           state_reg <= S_DONE;
                    endcase
                S_FILL:
                    if (sts.fill_last)
                        state_reg <= S_DONE;
                S_PLOT:
                begin
                    if (op_reg == OP_CIRCLE && sts.circ_done)
                        state_reg <= S_DONE;
                    else if (sts.on_screen)
                        state_reg <= S_WRITE;
                    else if (op_reg == OP_POINT)
                        state_reg <= S_DONE;
                    else if (op_reg == OP_LINE && sts.line_last)
                        state_reg <= S_DONE;
                end
                S_WRITE:
                begin
                    if (op_reg == OP_POINT)
                        state_reg <= S_DONE;
                    else if (op_reg == OP_LINE && sts.line_last)
                        state_reg <= S_DONE;
                    else
                        state_reg <= S_PLOT;
                end
                S_READ:  state_reg <= S_DONE;
                S_DONE:
                begin
                    out_valid <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

FILE: rtl/core/mono_framebuffer_line_circle_drawer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mono_framebuffer_line_circle_drawer: monochrome frame buffer drawing engine
// Clear/set all, point, line, circle and byte read-back over a paged store.
// ----------------------------------------------------------------------------
// One command is taken at a time and yields exactly one result transfer.
// Timing is set by the frame memory, with one write port and one registered
// read: a clear or set sweeps every byte, and each plotted on-screen pixel
// is a read-modify-write (read in S_PLOT, write in S_WRITE) while an
// off-screen point skips the write; a circle visits eight octant points
// per stepper iteration. After reset the engine clears the whole store
// and holds its input stalled until that is done, so the store starts all
// zero. A new command is accepted once the previous result has been taken
// or is taken that cycle.
// ----------------------------------------------------------------------------
module mono_framebuffer_line_circle_drawer
    import mfb_pkg::*;
#(
    parameter int SCREEN_WIDTH  = DEF_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = DEF_SCREEN_HEIGHT
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [2:0] opcode,
    input  logic [7:0] x_a,
    input  logic [7:0] y_a,
    input  logic [7:0] x_b,
    input  logic [7:0] y_b,
    input  logic [7:0] radius,
    input  logic       ink,
    input  logic [2:0] read_page,
    input  logic [6:0] read_column,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] read_data,
    output logic       was_read
);

    mfb_cmd_t cmd;
    mfb_sts_t sts;

    mfb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .opcode    (opcode),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .sts       (sts)
    );

    mfb_datapath #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .opcode      (opcode),
        .x_a         (x_a),
        .y_a         (y_a),
        .x_b         (x_b),
        .y_b         (y_b),
        .radius      (radius),
        .ink         (ink),
        .read_page   (read_page),
        .read_column (read_column),
        .read_data   (read_data),
        .was_read    (was_read)
    );

    // no transfer is taken in while a result is pending and stalled
    a_no_accept_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |-> in_stall)
        else $error("input accepted while result stalled");

    // a memory write always follows its read
    a_wr_after_rd: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.wr_issue |-> $past(cmd.rd_issue))
        else $error("write without preceding read");

    // a stalled result holds its payload
    a_result_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(read_data) && $stable(was_read)))
        else $error("stalled result changed");

endmodule
